[sv/skit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skit_pkg
// shared types, codes and defaults of the sorted key index table
// ----------------------------------------------------------------------------
package skit_pkg;

  localparam int unsigned CAPACITY_DEF  = 128;
  localparam int unsigned KEY_BYTES_DEF = 8;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    func_e       func;
    logic [63:0] key;
    logic [15:0] offset;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [6:0]  position;
    logic [15:0] found_offset;
    logic [7:0]  entry_count;
  } rsp_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic cmp_en;
    logic ins_go;
    logic rem_go;
  } cell_ctrl_t;

endpackage

[sv/skit_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skit_cell
// one table slot: holds a key and offset, compares against the request key
// and shifts with its neighbors on insert and remove
// ----------------------------------------------------------------------------
module skit_cell
  import skit_pkg::*;
#(
  parameter int unsigned KEY_W = 64
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             valid_i,
  input  logic [KEY_W-1:0] cmp_key_i,
  input  logic [KEY_W-1:0] new_key_i,
  input  logic [15:0]      new_off_i,
  input  logic             left_lt_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic [15:0]      left_off_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic [15:0]      right_off_i,
  output logic [KEY_W-1:0] key_o,
  output logic [15:0]      off_o,
  output logic             lt_o,
  output logic             eq_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [15:0]      off_q, off_d;
  logic             lt_q, eq_q;

  always_comb begin
    key_d = key_q;
    off_d = off_q;
    if (ctrl_i.ins_go && !lt_q) begin
      // boundary cell takes the new entry, cells above move up by one
      if (left_lt_i) begin
        key_d = new_key_i;
        off_d = new_off_i;
      end else begin
        key_d = left_key_i;
        off_d = left_off_i;
      end
    end else if (ctrl_i.rem_go && !lt_q) begin
      key_d = right_key_i;
      off_d = right_off_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    off_q <= off_d;
    if (ctrl_i.cmp_en) begin
      lt_q <= valid_i && (key_q < cmp_key_i);
      eq_q <= valid_i && (key_q == cmp_key_i);
    end
  end

  assign key_o = key_q;
  assign off_o = off_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

[sv/skit_sel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skit_sel
// resolves the registered cell flags into hit, position and stored offset
// ----------------------------------------------------------------------------
module skit_sel
  import skit_pkg::*;
#(
  parameter int unsigned CAPACITY = 128,
  localparam int unsigned IDX_W   = $clog2(CAPACITY)
) (
  input  logic [CAPACITY-1:0] lt_i,
  input  logic [CAPACITY-1:0] eq_i,
  input  logic [15:0]         off_i [CAPACITY],
  output logic                hit_o,
  output logic [IDX_W-1:0]    pos_o,
  output logic [15:0]         off_o
);

  logic [CAPACITY-1:0] bnd;

  // first cell whose key is not below the request key
  assign bnd = ~lt_i & {lt_i[CAPACITY-2:0], 1'b1};

  always_comb begin
    pos_o = '0;
    off_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd[i]) pos_o = pos_o | IDX_W'(i);
      if (eq_i[i]) off_o = off_o | off_i[i];
    end
  end

  assign hit_o = |eq_i;

endmodule

[sv/sorted_key_index_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_index_table
// sorted key table built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// the request is taken into the resolve state, and the result strobe done is registered from busy
// a new request is not taken while busy; busy is high for the resolve state
//   in which the cell flags are reduced and the chain shifts
// the result is shown for one cycle only, the receiver cannot stall
// reset clears the entry count and control; stored keys stay undefined
// ----------------------------------------------------------------------------
module sorted_key_index_table
  import skit_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done,
  output rsp_t rsp_o
);

  localparam int unsigned KEY_W = 8 * KEY_BYTES;
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_RESOLVE = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  req_t             req_q;
  logic             done_q;
  rsp_t             rsp_q, rsp_d;
  logic             accept;
  cell_ctrl_t       ctrl;

  // chain wiring
  logic [KEY_W-1:0]    key_w [CAPACITY];
  logic [15:0]         off_w [CAPACITY];
  logic [CAPACITY-1:0] lt_w;
  logic [CAPACITY-1:0] eq_w;

  logic             hit;
  logic [IDX_W-1:0] pos;
  logic [15:0]      hit_off;

  assign busy   = (state_q == ST_RESOLVE);
  assign accept = start && !busy;

  // cells compare on the accept edge, then shift at the end of resolve
  always_comb begin
    ctrl        = '0;
    ctrl.cmp_en = accept;
    rsp_d       = '0;
    rsp_d.status = ST_NOT_FOUND;
    count_d     = count_q;
    state_d     = accept ? ST_RESOLVE : ST_IDLE;
    if (busy) begin
      unique case (req_q.func)
        FUNC_INSERT: begin
          if (hit) begin
            rsp_d.status   = ST_DUPLICATE;
            rsp_d.position = 7'(pos);
          end else if (count_q == CNT_W'(CAPACITY)) begin
            rsp_d.status = ST_FULL;
          end else begin
            rsp_d.status   = ST_OK;
            rsp_d.position = 7'(pos);
            ctrl.ins_go    = 1'b1;
            count_d        = count_q + 1'b1;
          end
        end
        FUNC_LOOKUP: begin
          if (hit) begin
            rsp_d.status       = ST_OK;
            rsp_d.position     = 7'(pos);
            rsp_d.found_offset = hit_off;
          end
        end
        FUNC_REMOVE: begin
          if (hit) begin
            rsp_d.status       = ST_OK;
            rsp_d.position     = 7'(pos);
            rsp_d.found_offset = hit_off;
            ctrl.rem_go        = 1'b1;
            count_d            = count_q - 1'b1;
          end
        end
        default: begin
          // unused code leaves the table alone
        end
      endcase
      rsp_d.entry_count = 8'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= busy;
    end
  end

  // request and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    if (busy) rsp_q <= rsp_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             left_lt;
    logic [KEY_W-1:0] left_key, right_key;
    logic [15:0]      left_off, right_off;
    logic             valid;

    if (i == 0) begin : g_first
      // cell zero always sees an open slot below it
      assign left_lt  = 1'b1;
      assign left_key = '0;
      assign left_off = '0;
    end else begin : g_mid
      assign left_lt  = lt_w[i-1];
      assign left_key = key_w[i-1];
      assign left_off = off_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // top cell holds on remove, its contents become unused
      assign right_key = key_w[i];
      assign right_off = off_w[i];
    end else begin : g_low
      assign right_key = key_w[i+1];
      assign right_off = off_w[i+1];
    end

    assign valid = (count_q > CNT_W'(i));

    skit_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (valid),
      .cmp_key_i  (req_i.key[KEY_W-1:0]),
      .new_key_i  (req_q.key[KEY_W-1:0]),
      .new_off_i  (req_q.offset),
      .left_lt_i  (left_lt),
      .left_key_i (left_key),
      .left_off_i (left_off),
      .right_key_i(right_key),
      .right_off_i(right_off),
      .key_o      (key_w[i]),
      .off_o      (off_w[i]),
      .lt_o       (lt_w[i]),
      .eq_o       (eq_w[i])
    );
  end

  skit_sel #(
    .CAPACITY(CAPACITY)
  ) u_sel (
    .lt_i (lt_w),
    .eq_i (eq_w),
    .off_i(off_w),
    .hit_o(hit),
    .pos_o(pos),
    .off_o(hit_off)
  );

  assign done  = done_q;
  assign rsp_o = rsp_q;

endmodule

[sv/skit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skit_checker
// port-level checks on request and result timing and on result fields of the key table
// ----------------------------------------------------------------------------
module skit_checker
  import skit_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done,
  input rsp_t rsp_o
);

  logic accept;
  assign accept = start && !busy;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("busy not raised after request");

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done) else $error("result not delivered two cycles after request");

  a_done_only_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !busy && $past(busy)) else $error("result strobe without a resolve cycle");

  a_full_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && rsp_o.status == ST_FULL |-> rsp_o.position == '0 && rsp_o.found_offset == '0)
    else $error("full result carries position or offset");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> 32'(rsp_o.entry_count) <= CAPACITY) else $error("entry count above capacity");

endmodule

bind sorted_key_index_table skit_checker #(.CAPACITY(CAPACITY)) u_skit_checker (.*);
